### hdl/vbcc_pkg.sv
// ----------------------------------------------------------------------------
// vbcc_pkg
// Shared types and constants for the breath cycle controller: mode and stage
// codes, register indexes and the register set with its reset values.
// ----------------------------------------------------------------------------
package vbcc_pkg;

   typedef enum logic [1:0] {
      MODE_OFF = 2'd0,
      MODE_PC  = 2'd1,
      MODE_PS  = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      STAGE_OFF = 2'd0,
      STAGE_INH = 2'd1,
      STAGE_EXH = 2'd2
   } stage_type;

   typedef enum logic [2:0] {
      CSR_INSP_PRESSURE = 3'd0,
      CSR_PEEP_PRESSURE = 3'd1,
      CSR_INSP_TIME     = 3'd2,
      CSR_MAX_EXP_TIME  = 3'd3,
      CSR_APNEA_TIME    = 3'd4,
      CSR_TRIGGER_SENS  = 3'd5,
      CSR_CYCLE_OFF     = 3'd6
   } csr_index_type;

   localparam int CSR_DATA_W = 16;

   typedef struct packed {
      logic [6:0]         inspiratory_pressure;
      logic [5:0]         peep_pressure;
      logic [15:0]        inspiratory_time_ms;
      logic [15:0]        max_expiratory_time_ms;
      logic [15:0]        apnea_time_ms;
      logic signed [15:0] trigger_sensitivity;
      logic [8:0]         cycle_off_fraction;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      inspiratory_pressure:   7'd15,
      peep_pressure:          6'd5,
      inspiratory_time_ms:    16'd1000,
      max_expiratory_time_ms: 16'd2000,
      apnea_time_ms:          16'd20000,
      trigger_sensitivity:    -16'sd200,
      cycle_off_fraction:     9'd64
   };

endpackage

### hdl/vbcc_csr.sv
// ----------------------------------------------------------------------------
// vbcc_csr
// Configuration register bank; write-only, one register per write beat.
// ----------------------------------------------------------------------------
module vbcc_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [2:0]                        csr_index,
   input  logic [vbcc_pkg::CSR_DATA_W-1:0]   csr_write_data,
   output vbcc_pkg::cfg_type                 cfg
);

   vbcc_pkg::cfg_type cfg_ff;
   vbcc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (vbcc_pkg::csr_index_type'(csr_index))
            vbcc_pkg::CSR_INSP_PRESSURE: cfg_in.inspiratory_pressure   = csr_write_data[6:0];
            vbcc_pkg::CSR_PEEP_PRESSURE: cfg_in.peep_pressure          = csr_write_data[5:0];
            vbcc_pkg::CSR_INSP_TIME:     cfg_in.inspiratory_time_ms    = csr_write_data;
            vbcc_pkg::CSR_MAX_EXP_TIME:  cfg_in.max_expiratory_time_ms = csr_write_data;
            vbcc_pkg::CSR_APNEA_TIME:    cfg_in.apnea_time_ms          = csr_write_data;
            vbcc_pkg::CSR_TRIGGER_SENS:  cfg_in.trigger_sensitivity    = $signed(csr_write_data);
            vbcc_pkg::CSR_CYCLE_OFF:     cfg_in.cycle_off_fraction     = csr_write_data[8:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= vbcc_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hdl/ventilator_breath_cycle_controller.sv
// ----------------------------------------------------------------------------
// ventilator_breath_cycle_controller
// Breath cycling for pressure control and pressure support, one tick per beat.
// ----------------------------------------------------------------------------
// Path: request beat to input register, then the combinational state update,
// then result register to response beat. Throughput: one beat per cycle
// while the response side is not stalled by rsp_ready.
// Reset: mode off, stage off, timer and peak cleared, breath done set, apnea
// clear, setpoint zero, registers to their defaults, both pipeline slots empty.
module ventilator_breath_cycle_controller #(
   parameter int MIN_INHALE_MS = 500,
   parameter int TIMER_WIDTH   = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [15:0]              req_flow_sample,
   input  logic                            req_mode_write,
   input  logic [1:0]                      req_new_mode,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_breathing_stage,
   output logic [1:0]                      rsp_current_mode,
   output logic [7:0]                      rsp_desired_pressure,
   output logic                            rsp_breath_completed,
   output logic                            rsp_apnea_error,
   input  logic                            csr_write_enable,
   input  logic [2:0]                      csr_index,
   input  logic [vbcc_pkg::CSR_DATA_W-1:0] csr_write_data
);

   localparam int CMP_W = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

   vbcc_pkg::cfg_type cfg;

   vbcc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // input register
   logic               in_valid_ff, in_valid_in;
   logic signed [15:0] in_flow_ff;
   logic               in_mode_write_ff;
   logic [1:0]         in_new_mode_ff;

   // state
   vbcc_pkg::mode_type   mode_ff, mode_in;
   vbcc_pkg::stage_type  stage_ff, stage_in;
   logic [TIMER_WIDTH-1:0] elapsed_ff, elapsed_in;
   logic [14:0]          peak_ff, peak_in;
   logic                 done_ff, done_in;
   logic                 apnea_ff, apnea_in;
   logic [7:0]           setpoint_ff, setpoint_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_stage_ff;
   logic [1:0]           rsp_mode_ff;
   logic [7:0]           rsp_pressure_ff;
   logic                 rsp_done_ff;
   logic                 rsp_apnea_ff;

   logic req_fire;
   logic advance;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   // breath state update
   logic                 mode_ok;
   logic                 press_prev;
   logic                 press_next;
   logic [CMP_W-1:0]     elapsed_x;
   logic [7:0]           target;
   logic signed [24:0]   flow_scaled;
   logic [23:0]          peak_scaled;
   logic                 cycle_off;

   always_comb begin
      mode_ok    = in_new_mode_ff inside {vbcc_pkg::MODE_OFF, vbcc_pkg::MODE_PC,
                                          vbcc_pkg::MODE_PS};
      mode_in    = (in_mode_write_ff && mode_ok) ?
                   vbcc_pkg::mode_type'(in_new_mode_ff) : mode_ff;
      press_prev = (mode_ff == vbcc_pkg::MODE_PC) || (mode_ff == vbcc_pkg::MODE_PS);
      press_next = (mode_in == vbcc_pkg::MODE_PC) || (mode_in == vbcc_pkg::MODE_PS);

      stage_in    = stage_ff;
      elapsed_in  = elapsed_ff;
      peak_in     = peak_ff;
      done_in     = done_ff;
      apnea_in    = apnea_ff;
      setpoint_in = setpoint_ff;

      if (!press_prev && press_next) begin
         stage_in   = vbcc_pkg::STAGE_INH;
         elapsed_in = '0;
      end else if (elapsed_ff != {TIMER_WIDTH{1'b1}}) begin
         elapsed_in = elapsed_ff + 1'b1;
      end

      elapsed_x = CMP_W'(elapsed_in);
      target    = 8'(cfg.inspiratory_pressure) + 8'(cfg.peep_pressure);

      if ($signed(in_flow_ff) > $signed({1'b0, peak_ff}) &&
          mode_in == vbcc_pkg::MODE_PS && stage_in == vbcc_pkg::STAGE_INH) begin
         peak_in = in_flow_ff[14:0];
      end
      flow_scaled = 25'($signed({in_flow_ff, 8'b0}));
      peak_scaled = 24'(cfg.cycle_off_fraction) * 24'(peak_in);
      cycle_off   = flow_scaled < $signed({1'b0, peak_scaled});

      case (mode_in)
         vbcc_pkg::MODE_PC: begin
            if (stage_in == vbcc_pkg::STAGE_INH) begin
               done_in     = 1'b0;
               setpoint_in = target;
               if (elapsed_x >= CMP_W'(cfg.inspiratory_time_ms)) begin
                  stage_in    = vbcc_pkg::STAGE_EXH;
                  setpoint_in = '0;
                  elapsed_in  = '0;
               end
            end else if (stage_in == vbcc_pkg::STAGE_EXH) begin
               if (elapsed_x >= CMP_W'(cfg.max_expiratory_time_ms)) begin
                  stage_in   = vbcc_pkg::STAGE_INH;
                  done_in    = 1'b1;
                  elapsed_in = '0;
               end
            end
         end
         vbcc_pkg::MODE_PS: begin
            if (stage_in == vbcc_pkg::STAGE_INH) begin
               done_in     = 1'b0;
               setpoint_in = target;
               if (elapsed_x >= CMP_W'(MIN_INHALE_MS) && cycle_off) begin
                  stage_in    = vbcc_pkg::STAGE_EXH;
                  setpoint_in = '0;
                  elapsed_in  = '0;
               end
            end else if (stage_in == vbcc_pkg::STAGE_EXH) begin
               if (in_flow_ff <= $signed(cfg.trigger_sensitivity)) begin
                  stage_in   = vbcc_pkg::STAGE_INH;
                  done_in    = 1'b1;
                  elapsed_in = '0;
                  peak_in    = '0;
               end else if (elapsed_x >= CMP_W'(cfg.apnea_time_ms)) begin
                  mode_in    = vbcc_pkg::MODE_PC;
                  stage_in   = vbcc_pkg::STAGE_INH;
                  done_in    = 1'b1;
                  elapsed_in = '0;
                  apnea_in   = 1'b1;
               end
            end
         end
         default: begin
            stage_in = vbcc_pkg::STAGE_OFF;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= vbcc_pkg::MODE_OFF;
         stage_ff     <= vbcc_pkg::STAGE_OFF;
         elapsed_ff   <= '0;
         peak_ff      <= '0;
         done_ff      <= 1'b1;
         apnea_ff     <= 1'b0;
         setpoint_ff  <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            mode_ff     <= mode_in;
            stage_ff    <= stage_in;
            elapsed_ff  <= elapsed_in;
            peak_ff     <= peak_in;
            done_ff     <= done_in;
            apnea_ff    <= apnea_in;
            setpoint_ff <= setpoint_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_flow_ff       <= req_flow_sample;
         in_mode_write_ff <= req_mode_write;
         in_new_mode_ff   <= req_new_mode;
      end
      if (advance) begin
         rsp_stage_ff    <= stage_in;
         rsp_mode_ff     <= mode_in;
         rsp_pressure_ff <= setpoint_in;
         rsp_done_ff     <= done_in;
         rsp_apnea_ff    <= apnea_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_breathing_stage  = rsp_stage_ff;
   assign rsp_current_mode     = rsp_mode_ff;
   assign rsp_desired_pressure = rsp_pressure_ff;
   assign rsp_breath_completed = rsp_done_ff;
   assign rsp_apnea_error      = rsp_apnea_ff;

   // apnea flag is sticky until reset
   a_apnea_sticky: assert property (@(posedge clock) disable iff (reset)
      apnea_ff |=> apnea_ff)
      else $error("apnea flag cleared without reset");

   // off stage exactly when mode is off
   a_off_stage: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_mode_ff == vbcc_pkg::MODE_OFF) ==
                        (rsp_stage_ff == vbcc_pkg::STAGE_OFF)))
      else $error("stage and mode disagree on off");

   // no setpoint during exhalation
   a_exh_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stage_ff == vbcc_pkg::STAGE_EXH) |-> (rsp_pressure_ff == 8'd0))
      else $error("non-zero setpoint in exhalation");

   // a beat held in the input register is not lost while the output stalls
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("input beat dropped");

endmodule
